// ===== design/cgi_pkg.sv =====
// ----------------------------------------------------------------------------
// cgi_pkg
// Shared types and constants of the color gradient interpolator: the item
// structs, the command codes, the register map and the control structs
// between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package cgi_pkg;

	localparam int MAX_POINTS_DEF = 16;

	localparam int CH_W     = 8;              // one color channel
	localparam int PT_W     = 3 * CH_W;       // stored point {red, green, blue}
	localparam int IDX_W    = 4;              // point_index field
	localparam int LEN_W    = 5;              // path_length register
	localparam int STEP_W   = 16;             // segment tick count register
	localparam int ACC_W    = 17;             // signed 8.8 accumulator and step
	localparam int DIV_BITS = 16;             // quotient bits, one per cycle

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// command codes
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// register indexes, byte address is 4 * index
	localparam logic [1:0] REG_PATH_LENGTH = 2'd0;
	localparam logic [1:0] REG_STEPS       = 2'd1;
	localparam logic [1:0] REG_LOOP        = 2'd2;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [IDX_W-1:0] point_index;
		logic [CH_W-1:0]  point_red;
		logic [CH_W-1:0]  point_green;
		logic [CH_W-1:0]  point_blue;
	} in_item_t;

	typedef struct packed {
		logic            color_valid;
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
	} res_item_t;

	typedef struct packed {
		logic [LEN_W-1:0]  path_length;
		logic [STEP_W-1:0] seg_ticks;
		logic              loop_enable;
	} cfg_t;

	// sequencer -> datapath
	typedef struct packed {
		logic              load_a;     // capture segment start point
		logic              start_div;  // load accumulators, arm dividers
		logic              div_step;   // one quotient bit
		logic              fix;        // apply sign to quotients
		logic              emit_add;   // step accumulators, send color
		logic              emit_zero;  // send a not-running result
		logic [STEP_W-1:0] divisor;
	} dp_cmd_t;

	// datapath -> sequencer
	typedef struct packed {
		logic slot_free;
	} dp_stat_t;

endpackage

// ===== design/cgi_ram.sv =====
// ----------------------------------------------------------------------------
// cgi_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cgi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/cgi_dp.sv =====
// ----------------------------------------------------------------------------
// cgi_dp
// Datapath: per-channel accumulators and steps, three restoring dividers
// sharing one bit count, and the result register.
// ----------------------------------------------------------------------------
module cgi_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cgi_pkg::dp_cmd_t             cmd,
	output cgi_pkg::dp_stat_t            stat,
	input  logic [cgi_pkg::PT_W-1:0]     rd_point,
	output logic                         res_valid,
	input  logic                         res_stall,
	output cgi_pkg::res_item_t           res_item
);

	import cgi_pkg::*;

	localparam int NCH = 3;
	localparam int QW  = DIV_BITS;
	localparam int RW  = QW + 1;

	logic        [CH_W-1:0]  pa_q   [NCH];
	logic signed [ACC_W-1:0] acc_q  [NCH];
	logic signed [ACC_W-1:0] step_q [NCH];
	logic        [QW-1:0]    quo_q  [NCH];
	logic        [QW-1:0]    rem_q  [NCH];
	logic                    neg_q  [NCH];

	logic                    res_valid_q;
	res_item_t               res_q;

	logic        [CH_W-1:0]  pb     [NCH];
	logic        [CH_W-1:0]  mag    [NCH];
	logic        [RW-1:0]    trial  [NCH];
	logic                    fits   [NCH];
	logic signed [ACC_W-1:0] acc_nx [NCH];
	logic        [CH_W-1:0]  col_nx [NCH];
	logic        [RW-1:0]    dvs;

	assign dvs = {1'b0, cmd.divisor};

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			pb[c]     = rd_point[(NCH-1-c)*CH_W +: CH_W];
			mag[c]    = (pb[c] >= pa_q[c]) ? (pb[c] - pa_q[c]) : (pa_q[c] - pb[c]);
			trial[c]  = {rem_q[c], quo_q[c][QW-1]};
			fits[c]   = trial[c] >= dvs;
			acc_nx[c] = acc_q[c] + step_q[c];
			col_nx[c] = acc_nx[c][2*CH_W-1:CH_W];
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NCH; c++) begin
			if (cmd.load_a) begin
				pa_q[c] <= rd_point[(NCH-1-c)*CH_W +: CH_W];
			end
			if (cmd.start_div) begin
				acc_q[c] <= {1'b0, pa_q[c], {CH_W{1'b0}}};
				quo_q[c] <= {mag[c], {(QW-CH_W){1'b0}}};
				rem_q[c] <= '0;
				neg_q[c] <= pb[c] < pa_q[c];
			end else if (cmd.div_step) begin
				// remainder stays below the divisor, so it fits QW bits
				rem_q[c] <= fits[c] ? QW'(trial[c] - dvs) : trial[c][QW-1:0];
				quo_q[c] <= {quo_q[c][QW-2:0], fits[c]};
			end
			if (cmd.fix) begin
				step_q[c] <= neg_q[c] ? -$signed({1'b0, quo_q[c]}) : $signed({1'b0, quo_q[c]});
			end
			if (cmd.emit_add) begin
				acc_q[c] <= acc_nx[c];
			end
		end
		if (cmd.emit_zero) begin
			res_q <= '0;
		end else if (cmd.emit_add) begin
			res_q.color_valid <= 1'b1;
			res_q.out_red     <= col_nx[0];
			res_q.out_green   <= col_nx[1];
			res_q.out_blue    <= col_nx[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit_add || cmd.emit_zero) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign stat.slot_free = !res_valid_q || !res_stall;
	assign res_valid      = res_valid_q;
	assign res_item       = res_q;

`ifndef SYNTH
	// the sequencer only emits into a free result slot
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_add || cmd.emit_zero) |-> stat.slot_free)
		else $error("cgi_dp: emit into occupied result register");

	// never two emit kinds at once
	a_emit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_add && cmd.emit_zero))
		else $error("cgi_dp: conflicting emit commands");

	// a zero result never claims a valid color
	a_zero_res: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_zero |=> (res_valid && !res_item.color_valid))
		else $error("cgi_dp: zero result carries color_valid");
`endif

endmodule

// ===== design/cgi_ctrl.sv =====
// ----------------------------------------------------------------------------
// cgi_ctrl
// Sequencer: takes input transfers, drives the point RAM, walks segments and
// steers the datapath through point fetch, division and emit.
// ----------------------------------------------------------------------------
module cgi_ctrl #(
	parameter int MAX_POINTS = cgi_pkg::MAX_POINTS_DEF,
	localparam int AW = $clog2(MAX_POINTS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  cgi_pkg::in_item_t    in_item,
	input  cgi_pkg::cfg_t        cfg,
	output logic                 ram_we,
	output logic [AW-1:0]        ram_waddr,
	output logic [AW-1:0]        ram_raddr,
	output cgi_pkg::dp_cmd_t     dp_cmd,
	input  cgi_pkg::dp_stat_t    dp_stat
);

	import cgi_pkg::*;

	localparam int LW  = $clog2(MAX_POINTS + 1);
	localparam int CW  = (LW > LEN_W) ? LW : LEN_W;
	localparam int SW  = LW + 1;
	localparam int XW  = AW + IDX_W;
	localparam int DCW = $clog2(DIV_BITS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TICK = 3'd1;
	localparam logic [2:0] ST_RD_A = 3'd2;
	localparam logic [2:0] ST_RD_B = 3'd3;
	localparam logic [2:0] ST_LOAD = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_FIX  = 3'd6;

	logic [2:0]        state_q;
	logic              running_q;
	logic              tick_pend_q;
	logic [AW-1:0]     seg_q;
	logic [LW-1:0]     len_q;
	logic [STEP_W-1:0] steps_q;
	logic              loop_q;
	logic [STEP_W-1:0] left_q;
	logic [DCW-1:0]    div_cnt_q;

	logic              accept;
	logic [CW-1:0]     len_ext;
	logic [CW-1:0]     len_clip;
	logic              len_ok;
	logic [XW-1:0]     idx_ext;
	logic              idx_ok;
	logic              more_seg;
	logic              slot;
	logic              at_end;

	assign in_stall = state_q != ST_IDLE;
	assign accept   = in_valid && (state_q == ST_IDLE);

	assign len_ext  = CW'(cfg.path_length);
	assign len_clip = (len_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : len_ext;
	assign len_ok   = len_clip >= CW'(2);

	assign idx_ext   = {{AW{1'b0}}, in_item.point_index};
	assign idx_ok    = idx_ext < XW'(MAX_POINTS);
	assign ram_we    = accept && (in_item.cmd == CMD_LOAD) && idx_ok;
	assign ram_waddr = idx_ext[AW-1:0];
	assign ram_raddr = (state_q == ST_RD_A) ? seg_q : (seg_q + AW'(1));

	assign more_seg = (SW'(seg_q) + SW'(2)) < SW'(len_q);
	assign slot     = dp_stat.slot_free;
	assign at_end   = (left_q == '0) && !more_seg && !loop_q;

	always_comb begin
		dp_cmd           = '0;
		dp_cmd.load_a    = state_q == ST_RD_B;
		dp_cmd.start_div = state_q == ST_LOAD;
		dp_cmd.div_step  = state_q == ST_DIV;
		dp_cmd.fix       = state_q == ST_FIX;
		dp_cmd.divisor   = steps_q;
		dp_cmd.emit_add  = (state_q == ST_TICK) && running_q && (left_q != '0) && slot;
		dp_cmd.emit_zero = (state_q == ST_TICK) && slot && (!running_q || at_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			running_q   <= 1'b0;
			tick_pend_q <= 1'b0;
			seg_q       <= '0;
			len_q       <= '0;
			steps_q     <= STEP_W'(1);
			loop_q      <= 1'b0;
			left_q      <= '0;
			div_cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (in_item.cmd)
							CMD_START: begin
								if (len_ok) begin
									len_q       <= LW'(len_clip);
									steps_q     <= (cfg.seg_ticks == '0) ?
										STEP_W'(1) : cfg.seg_ticks;
									loop_q      <= cfg.loop_enable;
									running_q   <= 1'b1;
									tick_pend_q <= 1'b0;
									seg_q       <= '0;
									state_q     <= ST_RD_A;
								end
							end
							CMD_TICK: begin
								state_q <= ST_TICK;
							end
							default: begin
							end
						endcase
					end
				end
				ST_TICK: begin
					if (!running_q) begin
						if (slot) begin
							state_q <= ST_IDLE;
						end
					end else if (left_q == '0) begin
						if (more_seg) begin
							seg_q       <= seg_q + AW'(1);
							tick_pend_q <= 1'b1;
							state_q     <= ST_RD_A;
						end else if (loop_q) begin
							seg_q       <= '0;
							tick_pend_q <= 1'b1;
							state_q     <= ST_RD_A;
						end else if (slot) begin
							running_q <= 1'b0;
							state_q   <= ST_IDLE;
						end
					end else if (slot) begin
						left_q  <= left_q - STEP_W'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_RD_A: begin
					state_q <= ST_RD_B;
				end
				ST_RD_B: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					left_q    <= steps_q;
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + DCW'(1);
					if (div_cnt_q == DCW'(DIV_BITS - 1)) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					tick_pend_q <= 1'b0;
					state_q     <= tick_pend_q ? ST_TICK : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// segment setup only happens on a running gradient
	a_setup_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_TICK) |-> running_q)
		else $error("cgi_ctrl: segment setup while stopped");

	// current segment always has an end point inside the path
	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> ((SW'(seg_q) + SW'(1)) < SW'(len_q)))
		else $error("cgi_ctrl: segment index past path end");

	// the divisor is never zero
	a_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q != '0)
		else $error("cgi_ctrl: zero divisor latched");

	// a fresh segment carries its full step budget through the divide
	a_left_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_FIX) |-> (left_q == steps_q))
		else $error("cgi_ctrl: step count lost during setup");
`endif

endmodule

// ===== design/color_gradient_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// color_gradient_interpolator_top
// Piecewise linear RGB gradient: stores up to MAX_POINTS path points and
// steps an 8.8 color along them, one color per tick transfer.
// ----------------------------------------------------------------------------
// Timing: a load or unused-command transfer is taken while idle and leaves
// the block idle. A tick inside a segment is accepted, then the accumulate
// and the result register write follow. A start runs two point RAM reads
// (registered read port), one setup step, a restoring division (one
// quotient bit per cycle, three channels in parallel, divisor is the
// segment tick count), and one step to apply the sign. A tick that crosses
// into a new segment runs the same setup between its decision and its
// accumulate. The divider sets the segment change cost; one item is in
// flight at a time, and the input stalls until it is done. The
// result register lets the next transfer enter while a color waits on
// res_stall; a tick that finds the result register still full waits for it.
// Configuration (APB, pready tied high): path_length at 0x0, segment tick
// count at 0x4, loop_enable at 0x8; write only while the block is idle. The
// point RAM has no reset; a start must not read a point never loaded.
// ----------------------------------------------------------------------------
module color_gradient_interpolator_top #(
	parameter int MAX_POINTS = cgi_pkg::MAX_POINTS_DEF,
	localparam int AW = $clog2(MAX_POINTS)
) (
	input  logic                        clk,
	input  logic                        arst_n,

	// input item channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  cgi_pkg::in_item_t           in_item,

	// result channel
	output logic                        res_valid,
	input  logic                        res_stall,
	output cgi_pkg::res_item_t          res_item,

	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cgi_pkg::APB_AW-1:0]  paddr,
	input  logic [cgi_pkg::APB_DW-1:0]  pwdata,
	output logic [cgi_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	import cgi_pkg::*;

	cfg_t              cfg_q;
	logic              cfg_wr;
	logic [1:0]        reg_idx;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	logic [PT_W-1:0]   ram_rdata;

	dp_cmd_t           dp_cmd;
	dp_stat_t          dp_stat;

	// ------------------------------------------------------------------
	// Register file. Word index comes from paddr[3:2]; writes to the
	// unused fourth word are dropped and read back as zero.
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.path_length <= '0;
			cfg_q.seg_ticks   <= STEP_W'(1);
			cfg_q.loop_enable <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_PATH_LENGTH: cfg_q.path_length <= pwdata[LEN_W-1:0];
				REG_STEPS:       cfg_q.seg_ticks   <= pwdata[STEP_W-1:0];
				REG_LOOP:        cfg_q.loop_enable <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PATH_LENGTH: prdata = APB_DW'(cfg_q.path_length);
			REG_STEPS:       prdata = APB_DW'(cfg_q.seg_ticks);
			REG_LOOP:        prdata = APB_DW'(cfg_q.loop_enable);
			default:         prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: input transfers, segment walk, datapath commands.
	// ------------------------------------------------------------------
	cgi_ctrl #(
		.MAX_POINTS (MAX_POINTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.cfg       (cfg_q),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_raddr (ram_raddr),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat)
	);

	// ------------------------------------------------------------------
	// Path point store, {red, green, blue} per entry. Written straight
	// from the load transfer; read once for each end of a segment.
	// ------------------------------------------------------------------
	cgi_ram #(
		.WIDTH (PT_W),
		.DEPTH (MAX_POINTS)
	) u_points (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({in_item.point_red, in_item.point_green, in_item.point_blue}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Datapath: dividers, accumulators and the result register.
	// ------------------------------------------------------------------
	cgi_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.rd_point  (ram_rdata),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

// ===== verif/color_gradient_interpolator_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_gradient_interpolator_top_test
// Self-checking bench for the color gradient interpolator. A short stimulus
// table walks the reset state, short and restarted paths, zero steps and
// looping. Random phases follow, each with its own register setting. Every
// accepted transfer goes through a local gradient predictor, and each color
// transfer is compared field by field with the oldest predicted color.
// ----------------------------------------------------------------------------
module color_gradient_interpolator_top_test;

	import cgi_pkg::*;

	localparam int NPTS        = MAX_POINTS_DEF;
	localparam int IW          = $bits(in_item_t);
	localparam int RAND_ITEMS  = 1080;     // random transfers, unused commands included
	localparam int SETTLE_CYC  = 32;       // wait after draining, outlasts a segment change in the block
	localparam int QUIET_LIMIT = 4000;     // cycles with no transfer before giving up

	// colors that can be read straight off the gradient rules
	localparam res_item_t IDLE_C    = '{1'b0, 8'h00, 8'h00, 8'h00};
	localparam res_item_t LIT_WHITE = '{1'b1, 8'hff, 8'hff, 8'hff};
	localparam res_item_t LIT_GREEN = '{1'b1, 8'h00, 8'hff, 8'h00};

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

	// one row of the stimulus table: a transfer, or a register setting
	typedef struct packed {
		row_kind_e kind;
		in_item_t  item;
		logic      fixed;   // color typed in below instead of predicted
		res_item_t color;
		cfg_t      cfg;
	} dir_row_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_BEAT} stall_mode_e;

	// ------------------------------------------------------------------
	// DUT signals; every input starts at a known value
	// ------------------------------------------------------------------
	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	in_item_t           in_item   = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	res_item_t          res_item;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [APB_AW-1:0]  paddr     = '0;
	logic [APB_DW-1:0]  pwdata    = '0;
	logic [APB_DW-1:0]  prdata;
	logic               pready;

	color_gradient_interpolator_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Gradient predictor state: its own copy of the path, the 8.8
	// accumulators and steps, and the register values.
	// ------------------------------------------------------------------
	logic [PT_W-1:0]         pt_mem [NPTS];
	logic signed [ACC_W-1:0] acc_r, acc_g, acc_b;
	logic signed [ACC_W-1:0] stp_r, stp_g, stp_b;
	logic [IDX_W-1:0]        seg_cur;
	logic [STEP_W-1:0]       seg_left;
	logic                    grad_on;
	logic [LEN_W-1:0]        run_len;
	logic [STEP_W-1:0]       run_steps;
	logic                    run_loop;
	cfg_t                    cfg_now = '{5'd0, 16'd1, 1'b0};   // register reset values

	res_item_t color_q [$];   // predicted colors, oldest first

	int n_fail    = 0;
	int n_in      = 0;
	int n_colors  = 0;
	int n_lit     = 0;
	int n_phases  = 0;
	int quiet     = 0;
	int burst_left = 0;

	stall_mode_e stall_mode = STALL_NONE;
	int          stall_run  = 0;

	initial begin
		grad_on   = 1'b0;
		seg_cur   = '0;
		seg_left  = '0;
		run_len   = '0;
		run_steps = 16'd1;
		run_loop  = 1'b0;
		{acc_r, acc_g, acc_b, stp_r, stp_g, stp_b} = '0;
	end

	// per-tick increment of one channel, truncated toward zero
	function automatic logic signed [ACC_W-1:0] channel_step(logic [CH_W-1:0] from,
			logic [CH_W-1:0] to);
		int a;
		int b;
		int d;
		a = from;
		b = to;
		d = run_steps;
		return ACC_W'(((b - a) * 256) / d);
	endfunction

	// load accumulators with the segment's start point, steps toward its end
	function automatic void open_segment(int seg);
		logic [PT_W-1:0] a;
		logic [PT_W-1:0] b;
		a = pt_mem[seg];
		b = pt_mem[seg + 1];
		seg_cur  = IDX_W'(seg);
		acc_r    = {1'b0, a[23:16], 8'h00};
		acc_g    = {1'b0, a[15:8],  8'h00};
		acc_b    = {1'b0, a[7:0],   8'h00};
		stp_r    = channel_step(a[23:16], b[23:16]);
		stp_g    = channel_step(a[15:8],  b[15:8]);
		stp_b    = channel_step(a[7:0],   b[7:0]);
		seg_left = run_steps;
	endfunction

	// advance the predictor by one transfer; returns 1 when a color follows
	function automatic bit next_color(input in_item_t it, output res_item_t col);
		int len;
		int nxt;
		col = IDLE_C;
		case (it.cmd)
			CMD_LOAD: begin
				pt_mem[it.point_index] = {it.point_red, it.point_green, it.point_blue};
				return 1'b0;
			end
			CMD_START: begin
				len = cfg_now.path_length;
				if (len > NPTS)
					len = NPTS;
				if (len < 2)
					return 1'b0;      // short path: nothing happens
				run_len   = LEN_W'(len);
				run_steps = (cfg_now.seg_ticks == '0) ? 16'd1
				            : cfg_now.seg_ticks;
				run_loop  = cfg_now.loop_enable;
				grad_on   = 1'b1;
				open_segment(0);
				return 1'b0;
			end
			CMD_TICK: begin
				if (!grad_on)
					return 1'b1;
				if (seg_left == '0) begin
					nxt = int'(seg_cur) + 1;
					if (nxt < int'(run_len) - 1)
						open_segment(nxt);
					else if (run_loop)
						open_segment(0);
					else begin
						grad_on = 1'b0;   // path done: this tick reports idle
						return 1'b1;
					end
				end
				acc_r    = acc_r + stp_r;
				acc_g    = acc_g + stp_g;
				acc_b    = acc_b + stp_b;
				seg_left = seg_left - 1'b1;
				col = '{1'b1, acc_r[15:8], acc_g[15:8], acc_b[15:8]};
				return 1'b1;
			end
			default: return 1'b0;   // unused command
		endcase
	endfunction

	function automatic void note_fail(string msg);
		n_fail++;
		if (n_fail <= 10)
			$display("MISMATCH @%0t: %s", $time, msg);
	endfunction

	function automatic in_item_t rand_in(logic [1:0] cmd);
		in_item_t it;
		it     = in_item_t'(IW'($urandom));
		it.cmd = cmd;
		return it;
	endfunction

	// ------------------------------------------------------------------
	// Sender: bursts of random length split by random gaps. The payload
	// holds still until the transfer happens.
	// ------------------------------------------------------------------
	task automatic send_item(input in_item_t it, input bit fixed = 1'b0,
			input res_item_t want = '0);
		res_item_t col;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			// mostly short bursts, now and then a long run with no idling
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
			             : $urandom_range(1, 8);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		n_in++;
		if (next_color(it, col))
			color_q.push_back(fixed ? want : col);
	endtask

	// hold off the sender until every predicted color has been seen
	task automatic drain_colors();
		in_valid <= 1'b0;
		do @(posedge clk); while (color_q.size() != 0);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [APB_DW-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// registers change only with the block idle: colors drained, and time
	// for a start or segment change that produces no color to finish
	task automatic write_cfg(cfg_t cfg);
		drain_colors();
		repeat (SETTLE_CYC) @(posedge clk);
		apb_write(REG_PATH_LENGTH, APB_DW'(cfg.path_length));
		apb_write(REG_STEPS,       APB_DW'(cfg.seg_ticks));
		apb_write(REG_LOOP,        APB_DW'(cfg.loop_enable));
		cfg_now = cfg;
		n_phases++;
	endtask

	// ------------------------------------------------------------------
	// Receiver stall: its own pattern, switching among free flow, coin
	// flips, heavy back-pressure and a regular beat.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_mode = stall_mode_e'($urandom_range(0, 3));
			stall_run  = $urandom_range(8, 64);
		end else
			stall_run--;
		case (stall_mode)
			STALL_NONE:  res_stall <= 1'b0;
			STALL_COIN:  res_stall <= 1'($urandom_range(0, 1));
			STALL_HEAVY: res_stall <= ($urandom_range(0, 4) != 0);
			default:     res_stall <= stall_run[2];
		endcase
	end

	// ------------------------------------------------------------------
	// Color checker and idle counter for the watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin : color_chk
		res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			n_colors++;
			if (res_item.color_valid === 1'b1)
				n_lit++;
			if (color_q.size() == 0)
				note_fail($sformatf("color transfer %h with none predicted", res_item));
			else begin
				want = color_q.pop_front();
				if (res_item.color_valid !== want.color_valid)
					note_fail($sformatf("color_valid exp %b got %b",
						want.color_valid, res_item.color_valid));
				if (res_item.out_red !== want.out_red)
					note_fail($sformatf("out_red exp %h got %h",
						want.out_red, res_item.out_red));
				if (res_item.out_green !== want.out_green)
					note_fail($sformatf("out_green exp %h got %h",
						want.out_green, res_item.out_green));
				if (res_item.out_blue !== want.out_blue)
					note_fail($sformatf("out_blue exp %h got %h",
						want.out_blue, res_item.out_blue));
			end
		end
		if ((in_valid && !in_stall) || (res_valid && !res_stall))
			quiet = 0;
		else
			quiet++;
	end

	initial begin : watchdog
		wait (quiet >= QUIET_LIMIT);
		$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stim
		dir_row_t dir_tab [$];
		cfg_t     cfg;
		in_item_t it;
		int       n_rand;
		int       phase;
		int       span;
		int       pick;

		// Directed table. Typed colors: idle after reset, short path, a
		// one-step path jumping straight to each end point, stopping,
		// restart while running, and wrap-around when looping.
		dir_tab = '{
			'{ROW_ITEM, '{CMD_TICK,   4'h0, 8'h00, 8'h00, 8'h00}, 1'b1, IDLE_C,    '0},
			'{ROW_ITEM, '{CMD_START,  4'h0, 8'h00, 8'h00, 8'h00}, 1'b0, '0,        '0},
			'{ROW_ITEM, '{CMD_TICK,   4'h0, 8'h00, 8'h00, 8'h00}, 1'b1, IDLE_C,    '0},
			'{ROW_ITEM, '{CMD_UNUSED, 4'hf, 8'hff, 8'hff, 8'hff}, 1'b0, '0,        '0},
			'{ROW_CFG,  '0,                                       1'b0, '0,
				'{5'd1, 16'd1, 1'b0}},
			'{ROW_ITEM, '{CMD_START,  4'h0, 8'h00, 8'h00, 8'h00}, 1'b0, '0,        '0},
			'{ROW_ITEM, '{CMD_TICK,   4'h0, 8'h00, 8'h00, 8'h00}, 1'b1, IDLE_C,    '0},
			'{ROW_ITEM, '{CMD_LOAD,   4'h0, 8'h00, 8'h00, 8'h00}, 1'b0, '0,        '0},
			'{ROW_ITEM, '{CMD_LOAD,   4'h1, 8'hff, 8'hff, 8'hff}, 1'b0, '0,        '0},
			'{ROW_ITEM, '{CMD_LOAD,   4'h2, 8'h00, 8'hff, 8'h00}, 1'b0, '0,        '0},
			// zero steps per segment acts as one
			'{ROW_CFG,  '0,                                       1'b0, '0,
				'{5'd3, 16'd0, 1'b0}},
			'{ROW_ITEM, '{CMD_START,  4'h0, 8'h00, 8'h00, 8'h00}, 1'b0, '0,        '0},
			'{ROW_ITEM, '{CMD_TICK,   4'h0, 8'h00, 8'h00, 8'h00}, 1'b1, LIT_WHITE, '0},
			'{ROW_ITEM, '{CMD_TICK,   4'h0, 8'h00, 8'h00, 8'h00}, 1'b1, LIT_GREEN, '0},
			'{ROW_ITEM, '{CMD_TICK,   4'h0, 8'h00, 8'h00, 8'h00}, 1'b1, IDLE_C,    '0},
			'{ROW_ITEM, '{CMD_START,  4'h0, 8'h00, 8'h00, 8'h00}, 1'b0, '0,        '0},
			'{ROW_ITEM, '{CMD_TICK,   4'h0, 8'h00, 8'h00, 8'h00}, 1'b1, LIT_WHITE, '0},
			'{ROW_ITEM, '{CMD_START,  4'h0, 8'h00, 8'h00, 8'h00}, 1'b0, '0,        '0},
			'{ROW_ITEM, '{CMD_TICK,   4'h0, 8'h00, 8'h00, 8'h00}, 1'b1, LIT_WHITE, '0},
			'{ROW_CFG,  '0,                                       1'b0, '0,
				'{5'd3, 16'd0, 1'b1}},
			'{ROW_ITEM, '{CMD_START,  4'h0, 8'h00, 8'h00, 8'h00}, 1'b0, '0,        '0},
			'{ROW_ITEM, '{CMD_TICK,   4'h0, 8'h00, 8'h00, 8'h00}, 1'b1, LIT_WHITE, '0},
			'{ROW_ITEM, '{CMD_TICK,   4'h0, 8'h00, 8'h00, 8'h00}, 1'b1, LIT_GREEN, '0},
			'{ROW_ITEM, '{CMD_TICK,   4'h0, 8'h00, 8'h00, 8'h00}, 1'b1, LIT_WHITE, '0},
			// fractional steps, checked by the predictor
			'{ROW_CFG,  '0,                                       1'b0, '0,
				'{5'd3, 16'd3, 1'b1}},
			'{ROW_ITEM, '{CMD_START,  4'h0, 8'h00, 8'h00, 8'h00}, 1'b0, '0,        '0},
			'{ROW_ITEM, '{CMD_TICK,   4'h0, 8'h00, 8'h00, 8'h00}, 1'b0, '0,        '0},
			'{ROW_ITEM, '{CMD_TICK,   4'h0, 8'h00, 8'h00, 8'h00}, 1'b0, '0,        '0},
			'{ROW_ITEM, '{CMD_TICK,   4'h0, 8'h00, 8'h00, 8'h00}, 1'b0, '0,        '0}
		};

		// reset once at the start, then release it
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG)
				write_cfg(dir_tab[i].cfg);
			else
				send_item(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].color);
		end

		// Fill the whole path so that no start or segment change can ever
		// read a point that was never loaded.
		n_rand = 0;
		for (int i = 0; i < NPTS; i++) begin
			it = rand_in(CMD_LOAD);
			it.point_index = IDX_W'(i);
			send_item(it);
			n_rand++;
		end

		// Random phases: a register setting, a start, then mostly ticks with
		// loads, restarts and unused commands mixed in. The first phases pin
		// the extremes: full path, long path clamp, shortest path with zero
		// steps, largest step count, empty path.
		phase = 0;
		while (n_rand < RAND_ITEMS) begin
			case (phase)
				0: cfg = '{5'd16, 16'd3,     1'b1};
				1: cfg = '{5'd31, 16'd4,     1'b0};
				2: cfg = '{5'd2,  16'd0,     1'b1};
				3: cfg = '{5'd5,  16'd65535, 1'b0};
				4: cfg = '{5'd0,  16'd2,     1'b1};
				5: cfg = '{5'd16, 16'd1,     1'b1};
				default: begin
					cfg.path_length = ($urandom_range(0, 9) == 0)
					                  ? LEN_W'($urandom_range(0, 31))
					                  : LEN_W'($urandom_range(2, 16));
					pick = $urandom_range(0, 19);
					if (pick == 0)
						cfg.seg_ticks = 16'd0;
					else if (pick == 1)
						cfg.seg_ticks = 16'hffff;
					else if (pick == 2)
						cfg.seg_ticks = STEP_W'($urandom_range(0, 65535));
					else
						cfg.seg_ticks = STEP_W'($urandom_range(1, 12));
					cfg.loop_enable = 1'($urandom_range(0, 1));
				end
			endcase
			write_cfg(cfg);

			send_item(rand_in(CMD_START));
			n_rand++;
			span = $urandom_range(50, 130);
			for (int k = 0; k < span && n_rand < RAND_ITEMS; k++) begin
				// sender sometimes waits out all pending colors mid-phase, always in phase 1
				if (k == span / 2 && (phase == 1 || $urandom_range(0, 3) == 0))
					drain_colors();
				pick = $urandom_range(0, 99);
				if (pick < 70)
					it = rand_in(CMD_TICK);
				else if (pick < 82)
					it = rand_in(CMD_LOAD);
				else if (pick < 90)
					it = rand_in(CMD_START);
				else
					it = rand_in(CMD_UNUSED);
				send_item(it);
				n_rand++;
			end
			phase++;
		end

		// wind down: all colors in, then a quiet tail for anything stray
		drain_colors();
		repeat (SETTLE_CYC + 8) @(posedge clk);
		if (color_q.size() != 0)
			note_fail($sformatf("%0d predicted colors never arrived", color_q.size()));

		$display("run: %0d input transfers over %0d register settings",
			n_in, n_phases);
		$display("run: %0d color transfers checked, %0d with a live color, %0d errors",
			n_colors, n_lit, n_fail);
		if (n_fail == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
